// ----- rtl/srt_pkg.sv -----
// Shared constants and types for the slot reservation table.
`default_nettype none

package srt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TIME_W      = 16;
  localparam int OWNER_W     = 16;
  localparam int STATUS_W    = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_CANCEL  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_CANCELLED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } srt_state_t;

  // Commands from the sequencer to the table storage.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
  } srt_tbl_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OWNER_W-1:0]  clash_owner;
    logic [TIME_W-1:0]   clash_time;
  } srt_res_t;

endpackage

`default_nettype wire

// ----- rtl/srt_table.sv -----
// Entry storage: time and owner memories with registered reads, plus valid flags.
`default_nettype none

module srt_table (
  input  wire                           clk,
  input  wire                           rst_n,
  input  srt_pkg::srt_tbl_cmd_t         cmd,
  input  wire  [srt_pkg::TIME_W-1:0]    wr_time,
  input  wire  [srt_pkg::OWNER_W-1:0]   wr_owner,
  output logic [srt_pkg::TIME_W-1:0]    rd_time,
  output logic [srt_pkg::OWNER_W-1:0]   rd_owner,
  output logic [srt_pkg::TABLE_DEPTH-1:0] valid_vec
);
  import srt_pkg::*;

  logic [TIME_W-1:0]      time_mem  [TABLE_DEPTH];
  logic [OWNER_W-1:0]     owner_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] valid_nxt;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      time_mem[cmd.wr_addr]  <= wr_time;
      owner_mem[cmd.wr_addr] <= wr_owner;
    end
    if (cmd.rd_en) begin
      rd_time  <= time_mem[cmd.rd_addr];
      rd_owner <= owner_mem[cmd.rd_addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.wr_en) begin
      valid_nxt[cmd.wr_addr] = 1'b1;
    end
    if (cmd.clr_en) begin
      valid_nxt[cmd.clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign valid_vec = valid_r;

endmodule

`default_nettype wire

// ----- rtl/srt_cmp.sv -----
// Shared distance compare: flags when |a - b| is at most the given limit.
`default_nettype none

module srt_cmp (
  input  wire [srt_pkg::TIME_W-1:0] a,
  input  wire [srt_pkg::TIME_W-1:0] b,
  input  wire [srt_pkg::TIME_W-1:0] limit,
  output logic                      near
);
  import srt_pkg::*;

  logic [TIME_W-1:0] delta;

  always_comb begin
    delta = (a > b) ? (a - b) : (b - a);
    near  = (delta <= limit);
  end

endmodule

`default_nettype wire

// ----- rtl/srt_seq.sv -----
// Sequencer: walks the table one entry a cycle through the shared compare unit.
`default_nettype none

module srt_seq (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire                              in_action,
  input  wire  [srt_pkg::TIME_W-1:0]       in_time,
  input  wire  [srt_pkg::OWNER_W-1:0]      in_owner,
  input  wire  [srt_pkg::TIME_W-1:0]       min_gap,
  input  wire                              res_room,
  input  wire  [srt_pkg::TABLE_DEPTH-1:0]  valid_vec,
  input  wire  [srt_pkg::TIME_W-1:0]       rd_time,
  input  wire  [srt_pkg::OWNER_W-1:0]      rd_owner,
  output logic                             busy,
  output srt_pkg::srt_tbl_cmd_t            tbl_cmd,
  output logic [srt_pkg::TIME_W-1:0]       wr_time,
  output logic [srt_pkg::OWNER_W-1:0]      wr_owner,
  output logic                             res_valid,
  output srt_pkg::srt_res_t                res
);
  import srt_pkg::*;

  srt_state_t         state_r, state_nxt;
  logic               act_r, act_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [OWNER_W-1:0] c_owner_r, c_owner_nxt;
  logic [TIME_W-1:0]  c_time_r, c_time_nxt;

  logic [TIME_W-1:0]  limit;
  logic               near;
  logic               vbit;

  // A cancel needs an exact match, which is a distance limit of zero.
  assign limit = (act_r == ACT_CANCEL) ? '0 : min_gap;

  srt_cmp u_cmp (
    .a     (rd_time),
    .b     (time_r),
    .limit (limit),
    .near  (near)
  );

  assign vbit     = valid_vec[cmp_idx_r];
  assign busy     = (state_r != ST_IDLE);
  assign wr_time  = time_r;
  assign wr_owner = owner_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    time_nxt       = time_r;
    owner_nxt      = owner_r;
    cnt_nxt        = cnt_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    c_owner_nxt    = c_owner_r;
    c_time_nxt     = c_time_r;
    tbl_cmd        = '0;
    res_valid      = 1'b0;
    res            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt        = in_action;
          time_nxt       = in_time;
          owner_nxt      = in_owner;
          cnt_nxt        = '0;
          issue_done_nxt = 1'b0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tbl_cmd.rd_en   = !issue_done_r;
        tbl_cmd.rd_addr = cnt_r;
        cmp_vld_nxt     = !issue_done_r;
        cmp_idx_nxt     = cnt_r;
        if (!issue_done_r) begin
          if (cnt_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        // Read data comes back in the cycle after its address is issued.
        if (cmp_vld_r) begin
          if (vbit && near) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            c_owner_nxt = rd_owner;
            c_time_nxt  = rd_time;
            state_nxt   = ST_FINISH;
          end else begin
            if (!vbit && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = cmp_idx_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end
      ST_FINISH: begin
        if (res_room) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
          if (act_r == ACT_CANCEL) begin
            if (hit_r) begin
              res.status       = STATUS_CANCELLED;
              tbl_cmd.clr_en   = 1'b1;
              tbl_cmd.clr_addr = hit_idx_r;
            end else begin
              res.status = STATUS_NOT_FOUND;
            end
          end else if (hit_r) begin
            res.status      = STATUS_CONFLICT;
            res.clash_owner = c_owner_r;
            res.clash_time  = c_time_r;
          end else if (free_found_r) begin
            res.status      = STATUS_ACCEPTED;
            tbl_cmd.wr_en   = 1'b1;
            tbl_cmd.wr_addr = free_idx_r;
          end else begin
            res.status = STATUS_FULL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    time_r       <= time_nxt;
    owner_r      <= owner_nxt;
    cnt_r        <= cnt_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    c_owner_r    <= c_owner_nxt;
    c_time_r     <= c_time_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/slot_reservation_table.sv -----
// Top level of the slot reservation table: channels, gap register and result register.
//
// The block keeps up to TABLE_DEPTH reserved times, each with an owner id.
// Input beats (in_valid / in_stall) carry an action, a slot time and an owner.
// A request is admitted into the lowest free slot only when every stored time
// lies more than min_gap away; otherwise the lowest conflicting entry is
// reported, or a full status is given when no slot is free. A cancel removes
// the entry whose time matches exactly.
// Each input beat yields exactly one result beat (out_valid / out_stall).
// The min_gap register is written through cfg_valid / cfg_ready / cfg_min_gap
// and should only change while the block is idle; cfg_ready is always high.
// Each item walks the table one entry per cycle through a single
// compare unit and a registered memory read; the walk ends early when a
// conflict or a cancel match is found. in_stall stays high during that
// walk and until the result is passed on, so the block takes no new item
// before it is through with the current one.
// A finished result sits in an output register; if the receiver stalls, the
// block still accepts the next item and only holds its final step until the
// register frees. Synchronous reset empties the table and clears min_gap.

`default_nettype none

module slot_reservation_table (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [srt_pkg::TIME_W-1:0]       cfg_min_gap,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_action,
  input  wire  [srt_pkg::TIME_W-1:0]       in_slot_time,
  input  wire  [srt_pkg::OWNER_W-1:0]      in_owner_id,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [srt_pkg::STATUS_W-1:0]     out_status,
  output logic [srt_pkg::OWNER_W-1:0]      out_clash_owner,
  output logic [srt_pkg::TIME_W-1:0]       out_clash_time
);
  import srt_pkg::*;

  logic [TIME_W-1:0]      min_gap_r;
  logic                   out_valid_r;
  srt_res_t               out_res_r;

  logic                   busy;
  logic                   start;
  logic                   res_room;
  logic                   res_valid;
  srt_res_t               res;
  srt_tbl_cmd_t           tbl_cmd;
  logic [TIME_W-1:0]      wr_time;
  logic [OWNER_W-1:0]     wr_owner;
  logic [TIME_W-1:0]      rd_time;
  logic [OWNER_W-1:0]     rd_owner;
  logic [TABLE_DEPTH-1:0] valid_vec;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;

  // The output register can take a new beat when empty or being drained.
  assign res_room  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_gap_r <= cfg_min_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_clash_owner = out_res_r.clash_owner;
  assign out_clash_time  = out_res_r.clash_time;

  srt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .in_time   (in_slot_time),
    .in_owner  (in_owner_id),
    .min_gap   (min_gap_r),
    .res_room  (res_room),
    .valid_vec (valid_vec),
    .rd_time   (rd_time),
    .rd_owner  (rd_owner),
    .busy      (busy),
    .tbl_cmd   (tbl_cmd),
    .wr_time   (wr_time),
    .wr_owner  (wr_owner),
    .res_valid (res_valid),
    .res       (res)
  );

  srt_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (tbl_cmd),
    .wr_time   (wr_time),
    .wr_owner  (wr_owner),
    .rd_time   (rd_time),
    .rd_owner  (rd_owner),
    .valid_vec (valid_vec)
  );

endmodule

`default_nettype wire

// ----- rtl/srt_checker.sv -----
// Port-level checks for the slot reservation table, bound to the top level.
`default_nettype none

module srt_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [srt_pkg::STATUS_W-1:0]  out_status,
  input wire [srt_pkg::OWNER_W-1:0]   out_clash_owner,
  input wire [srt_pkg::TIME_W-1:0]    out_clash_time
);
  import srt_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // After taking an item the block is busy walking the table.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after an accept");

  // Clash fields carry data only with a conflict status.
  a_clash_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_CONFLICT) |->
      (out_clash_owner == '0) && (out_clash_time == '0))
    else $error("clash fields set without a conflict");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_ACCEPTED) || (out_status == STATUS_CONFLICT) ||
      (out_status == STATUS_FULL) || (out_status == STATUS_CANCELLED) ||
      (out_status == STATUS_NOT_FOUND))
    else $error("undefined status code");

endmodule

bind slot_reservation_table srt_checker u_srt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_clash_owner (out_clash_owner),
  .out_clash_time  (out_clash_time)
);

`default_nettype wire
